// ===== hw/rtl/irqsg_pkg.sv =====
`default_nettype none

package irqsg_pkg;

	localparam int NUM_LINES_DEF   = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int CMD_W       = 2;
	localparam int VEC_W       = 8;
	localparam int LINE_W      = 4;
	localparam int ACT_W       = 3;
	localparam int MASK_W      = 16;
	localparam int THR_W       = 32;
	localparam int PERIOD_W    = 16;
	localparam int TICK_W      = 64;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 120;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [VEC_W-1:0] VEC_BASE        = 8'h20;
	localparam logic [VEC_W-1:0] VEC_MASTER_SPUR = 8'd39;
	localparam logic [VEC_W-1:0] VEC_SLAVE_FIRST = 8'd40;
	localparam logic [VEC_W-1:0] VEC_SLAVE_SPUR  = 8'd47;

	localparam logic [THR_W-1:0]    THRESHOLD_RST = 32'd1500;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd100;
	localparam logic [MASK_W-1:0]   MASK_RST      = 16'hFFFE;

	typedef enum logic [CMD_W-1:0] {
		CMD_EVENT  = 2'd0,
		CMD_POLL   = 2'd1,
		CMD_UNMASK = 2'd2,
		CMD_MASK   = 2'd3
	} cmd_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_SPUR_DROP  = 3'd0,
		ACT_SPUR_SLAVE = 3'd1,
		ACT_TIMER      = 3'd2,
		ACT_HANDLER    = 3'd3,
		ACT_UNHANDLED  = 3'd4,
		ACT_FATAL      = 3'd5,
		ACT_DONE       = 3'd6
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_PERIOD    = 2'd1,
		REG_HANDLER   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              bump;
		logic [LINE_W-1:0] line;
		logic              sweep;
	} cnt_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/irqsg_counters.sv =====
`default_nettype none

module irqsg_counters
	import irqsg_pkg::*;
#(
	parameter int NUM_LINES   = NUM_LINES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cnt_ctrl_t         ctrl,
	input  wire logic [THR_W-1:0]  threshold,
	output logic      [MASK_W-1:0] hits
);

	logic [COUNT_WIDTH-1:0] cnt_q [1:NUM_LINES-1];

	assign hits[0] = 1'b0;

	for (genvar i = 1; i < NUM_LINES; i++) begin : g_line
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q[i] <= '0;
			end else if (ctrl.sweep) begin
				cnt_q[i] <= '0;
			end else if (ctrl.bump && ctrl.line == LINE_W'(i) && cnt_q[i] != '1) begin
				cnt_q[i] <= cnt_q[i] + 1'b1;
			end
		end

		assign hits[i] = THR_W'(cnt_q[i]) >= threshold;
	end

	if (NUM_LINES < MASK_W) begin : g_pad
		assign hits[MASK_W-1:NUM_LINES] = '0;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/irq_dispatch_storm_guard_top.sv =====
// An accepted request is registered into data_s1, and its result from there into m_tdata with m_tvalid.
// Throughput: one request per cycle; s_tready drops only while the output is stalled.
// The counter sweep compares all line counters against the threshold together, combinationally.
// Reset (arst_n low, asynchronous) clears counters, flags, ticks and sweep phase,
// sets the line mask to 0xFFFE and loads the default threshold and sweep period.
`default_nettype none

module irq_dispatch_storm_guard_top
	import irqsg_pkg::*;
#(
	parameter int NUM_LINES   = NUM_LINES_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// command[1:0], vector[9:2], in_service[10], line[14:11], zero[15]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// action[2:0], eoi_master[3], eoi_slave[4], irq_enter[5], meter_tick[6],
	// line_mask[22:7], storm_lines[38:23], unhandled_lines[54:39],
	// tick_count[118:55], zero[119]
	output logic      [OUT_TDATA_W-1:0] m_tdata,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [MASK_W-1:0] UPPER_LINES = MASK_W'(~((17'd1 << NUM_LINES) - 17'd1));

	logic [THR_W-1:0]    threshold_q;
	logic [PERIOD_W-1:0] period_q;
	logic [MASK_W-1:0]   handler_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			period_q    <= PERIOD_RST;
			handler_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: threshold_q <= cfg_data;
				REG_PERIOD:    period_q    <= cfg_data[PERIOD_W-1:0];
				REG_HANDLER:   handler_q   <= cfg_data[MASK_W-1:0];
				default:       ;
			endcase
		end
	end

	logic                   valid_s1;
	logic [IN_TDATA_W-1:0]  data_s1;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   advance;

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
	end

	cmd_t              cmd;
	logic [VEC_W-1:0]  vec;
	logic              isr;
	logic [LINE_W-1:0] line;
	logic [LINE_W-1:0] irq;

	assign cmd  = cmd_t'(data_s1[1:0]);
	assign vec  = data_s1[9:2];
	assign isr  = data_s1[10];
	assign line = data_s1[14:11];
	assign irq  = vec[LINE_W-1:0];

	logic [MASK_W-1:0]   mask_q;
	logic [MASK_W-1:0]   storm_q;
	logic [MASK_W-1:0]   unh_q;
	logic [TICK_W-1:0]   ticks_q;
	logic [PERIOD_W-1:0] phase_q;

	logic [MASK_W-1:0]   mask_d;
	logic [MASK_W-1:0]   storm_d;
	logic [MASK_W-1:0]   unh_d;
	logic [TICK_W-1:0]   ticks_d;
	logic [PERIOD_W-1:0] phase_d;
	logic [MASK_W-1:0]   hits;
	logic [PERIOD_W:0]   phase_inc;
	logic                irq_range;
	logic                line_irq_ok;
	logic                line_cmd_ok;
	logic                is_timer;
	logic                do_sweep;
	logic                do_bump;
	action_t             action_d;
	logic                eoi_m_d;
	logic                eoi_s_d;
	logic                enter_d;
	logic [MASK_W-1:0]   storms_out;
	logic [MASK_W-1:0]   unh_out;
	cnt_ctrl_t           cnt_ctrl;

	assign irq_range   = vec[VEC_W-1:LINE_W] == VEC_BASE[VEC_W-1:LINE_W];
	assign line_irq_ok = 32'(irq) < NUM_LINES;
	assign line_cmd_ok = 32'(line) < NUM_LINES;
	assign phase_inc   = {1'b0, phase_q} + 1'b1;

	always_comb begin
		mask_d     = mask_q;
		storm_d    = storm_q;
		unh_d      = unh_q;
		ticks_d    = ticks_q;
		phase_d    = phase_q;
		action_d   = ACT_DONE;
		eoi_m_d    = 1'b0;
		eoi_s_d    = 1'b0;
		enter_d    = 1'b0;
		is_timer   = 1'b0;
		do_sweep   = 1'b0;
		do_bump    = 1'b0;
		storms_out = '0;
		unh_out    = '0;
		case (cmd)
			CMD_EVENT: begin
				enter_d = irq_range;
				if (vec == VEC_MASTER_SPUR && !isr) begin
					action_d = ACT_SPUR_DROP;
				end else if (vec == VEC_SLAVE_SPUR && !isr) begin
					action_d = ACT_SPUR_SLAVE;
					eoi_m_d  = 1'b1;
				end else if (vec == VEC_BASE) begin
					is_timer = 1'b1;
					ticks_d  = ticks_q + 1'b1;
					eoi_m_d  = 1'b1;
					action_d = ACT_TIMER;
					if (phase_inc >= {1'b0, period_q}) begin
						phase_d  = '0;
						do_sweep = 1'b1;
						mask_d   = mask_q | hits;
						storm_d  = storm_q | hits;
					end else begin
						phase_d = phase_inc[PERIOD_W-1:0];
					end
				end else if (irq_range && line_irq_ok) begin
					do_bump = 1'b1;
					eoi_m_d = 1'b1;
					eoi_s_d = vec >= VEC_SLAVE_FIRST;
					if (handler_q[irq]) begin
						action_d = ACT_HANDLER;
					end else begin
						mask_d[irq] = 1'b1;
						unh_d[irq]  = 1'b1;
						action_d    = ACT_UNHANDLED;
					end
				end else begin
					action_d = ACT_FATAL;
				end
			end
			CMD_POLL: begin
				storms_out = storm_q;
				unh_out    = unh_q;
				storm_d    = '0;
				unh_d      = '0;
			end
			CMD_UNMASK: begin
				if (line_cmd_ok) begin
					mask_d[line] = 1'b0;
				end
			end
			CMD_MASK: begin
				if (line_cmd_ok) begin
					mask_d[line] = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign cnt_ctrl.bump  = advance && do_bump;
	assign cnt_ctrl.line  = irq;
	assign cnt_ctrl.sweep = advance && do_sweep;

	irqsg_counters #(
		.NUM_LINES   (NUM_LINES),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counters (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (cnt_ctrl),
		.threshold (threshold_q),
		.hits      (hits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= MASK_RST;
			storm_q <= '0;
			unh_q   <= '0;
			ticks_q <= '0;
			phase_q <= '0;
		end else if (advance) begin
			mask_q  <= mask_d;
			storm_q <= storm_d;
			unh_q   <= unh_d;
			ticks_q <= ticks_d;
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {1'b0, ticks_d, unh_out, storms_out, mask_d,
				is_timer, enter_d, eoi_s_d, eoi_m_d, action_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_timer_mask_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd == CMD_EVENT |=> mask_q[0] == $past(mask_q[0]))
		else $error("event changed the timer line mask");

	a_poll_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd == CMD_POLL |=> storm_q == '0 && unh_q == '0)
		else $error("poll left flags set");

	a_ticks_only_timer: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && is_timer) |=> ticks_q == $past(ticks_q))
		else $error("tick count moved without a timer event");

	a_upper_masked: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q & UPPER_LINES) == UPPER_LINES)
		else $error("mask cleared on a line past the last one");

	a_no_sweep_flag_on_line0: assert property (@(posedge clk) disable iff (!arst_n)
		!storm_q[0] && !unh_q[0])
		else $error("timer line flagged");

endmodule

`default_nettype wire
